// ===== hdl/julian_day_to_calendar_date_macros.svh =====
// Assertion macros for the date converter RTL.
`ifndef JULIAN_DAY_TO_CALENDAR_DATE_MACROS_SVH
`define JULIAN_DAY_TO_CALENDAR_DATE_MACROS_SVH
`ifndef SYNTHESIS
`define JDCD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define JDCD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define JDCD_ASSERT(label, clk, rst_n, prop, msg)
`define JDCD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/jdcd_pkg.sv =====
`timescale 1ns / 1ps
package jdcd_pkg;

  localparam logic [31:0] LastJulianDay = 32'd2299160;
  localparam logic [31:0] GregOffset    = 32'd32044;
  localparam logic [31:0] JulOffset     = 32'd32082;
  localparam logic [17:0] GregCycle     = 18'd146097;
  localparam logic [10:0] JulCycle      = 11'd1461;
  localparam logic [6:0]  CenturyYears  = 7'd100;
  localparam logic [25:0] EpochYear     = 26'd4800;
  localparam logic [23:0] MaxBcYear     = 24'd4714;
  localparam logic [8:0]  MaxDayOffset  = 9'd365;
  localparam int unsigned ResultLatency = 8;

  // Reciprocal of the 400-year cycle, applied to the upper 18 bits of a 35-bit dividend.
  localparam logic [23:0] GregRecip = 24'((64'd1 << 41) / 64'd146097);
  // Rounded-up reciprocal of the 4-year cycle, exact for any 24-bit dividend.
  localparam logic [24:0] JulRecip  = 25'(((64'd1 << 35) + 64'd1460) / 64'd1461);

  typedef struct packed {
    logic [4:0] day;
    logic [3:0] month;
    logic       wrap;
  } month_split_t;

  // Day offset of each month start, counted from 1 March.
  function automatic logic [8:0] month_start(input logic [3:0] idx);
    logic [8:0] start;
    unique case (idx)
      4'd0:    start = 9'd0;
      4'd1:    start = 9'd31;
      4'd2:    start = 9'd61;
      4'd3:    start = 9'd92;
      4'd4:    start = 9'd122;
      4'd5:    start = 9'd153;
      4'd6:    start = 9'd184;
      4'd7:    start = 9'd214;
      4'd8:    start = 9'd245;
      4'd9:    start = 9'd275;
      4'd10:   start = 9'd306;
      4'd11:   start = 9'd337;
      default: start = 9'd0;
    endcase
    return start;
  endfunction

endpackage

// ===== hdl/jdcd_month_split.sv =====
`timescale 1ns / 1ps
module jdcd_month_split import jdcd_pkg::*; (
  input  logic [8:0]   day_offset_i,
  output month_split_t split_o
);

  logic [3:0] idx;
  logic [8:0] base;

  always_comb begin
    idx  = 4'd0;
    base = 9'd0;
    for (int k = 1; k < 12; k++) begin
      if (day_offset_i >= month_start(4'(k))) begin
        idx  = 4'(k);
        base = month_start(4'(k));
      end
    end
    split_o.day = 5'(day_offset_i - base + 9'd1);
    if (idx >= 4'd10) begin
      split_o.month = idx - 4'd9;
      split_o.wrap  = 1'b1;
    end else begin
      split_o.month = idx + 4'd3;
      split_o.wrap  = 1'b0;
    end
  end

endmodule

// ===== hdl/julian_day_to_calendar_date.sv =====
// Seven-stage pipeline; stage four has two multipliers, every other stage at most one.
// A word accepted at a clock edge passes the input register and the pipeline stages to the result ports,
// with result_valid_o high for one cycle.
// Throughput is one word per clock; busy never rises and the receiver cannot stall.
// Reset clears the valid pipeline, so no result appears until a new word is accepted.
`timescale 1ns / 1ps
`include "julian_day_to_calendar_date_macros.svh"
module julian_day_to_calendar_date import jdcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic [31:0] julian_day_i,
  output logic        busy,
  output logic        result_valid_o,
  output logic [4:0]  day_of_month_o,
  output logic [3:0]  month_o,
  output logic [23:0] year_o,
  output logic        before_christ_o
);

  logic [7:0]  valid_q;
  logic [31:0] jd_q;

  logic [32:0] a_d;
  logic [34:0] n1_d;
  logic [41:0] p1_d;
  logic        greg1_d;
  logic [21:0] cjul1_d;
  logic [34:0] n1_q;
  logic [41:0] p1_q;
  logic        greg1_q;
  logic [21:0] cjul1_q;

  logic [17:0] q0_d;
  logic [34:0] t_d;
  logic [34:0] n2_q;
  logic [17:0] q0_q;
  logic [34:0] t_q;
  logic        greg2_q;
  logic [21:0] cjul2_q;

  logic [34:0] r_raw;
  logic [18:0] r_fix;
  logic [17:0] b_d;
  logic [21:0] c3_d;
  logic [21:0] c3_q;
  logic [17:0] b3_q;
  logic        greg3_q;

  logic [23:0] n4;
  logic [48:0] p4_d;
  logic [24:0] yb4_d;
  logic [21:0] c4_q;
  logic [48:0] p4_q;
  logic [24:0] yb4_q;

  logic [12:0] d5_d;
  logic [23:0] t5_d;
  logic [21:0] c5_q;
  logic [12:0] d5_q;
  logic [23:0] t5_q;
  logic [24:0] yb5_q;

  logic [8:0]  e6_d;
  logic [8:0]  e6_q;
  logic [12:0] d6_q;
  logic [24:0] yb6_q;

  month_split_t split;
  logic [25:0]  ysum;
  logic         bc_d;
  logic [23:0]  year_d;
  logic [4:0]   day_q;
  logic [3:0]   month_q;
  logic [23:0]  year_q;
  logic         bc_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[6:0], start};
    end
  end

  // Stage one: estimate of the 400-year cycle count from the upper dividend bits.
  always_comb begin
    a_d     = {1'b0, jd_q} + {1'b0, GregOffset};
    n1_d    = {a_d[32:0], 2'b11};
    p1_d    = 42'(n1_d[34:17]) * 42'(GregRecip);
    greg1_d = jd_q > LastJulianDay;
    cjul1_d = 22'(jd_q + JulOffset);
  end

  // Stage two: back-multiply the estimate.
  always_comb begin
    q0_d = p1_q[41:24];
    t_d  = 35'(36'(q0_d) * 36'(GregCycle));
  end

  // Stage three: one correction step, then the day within the cycle (Julian dates pass the shifted day number).
  always_comb begin
    r_raw = n2_q - t_q;
    r_fix = r_raw[18:0];
    b_d   = q0_q;
    if (r_fix >= 19'(GregCycle)) begin
      r_fix = r_fix - 19'(GregCycle);
      b_d   = q0_q + 18'd1;
    end
    c3_d = greg2_q ? 22'(r_fix[18:2]) : cjul2_q;
  end

  // Stage four: 4-year cycle count by reciprocal, and the century part of the year.
  always_comb begin
    n4    = {c3_q, 2'b11};
    p4_d  = 49'(n4) * 49'(JulRecip);
    yb4_d = greg3_q ? 25'(b3_q) * 25'(CenturyYears) : 25'd0;
  end

  always_comb begin
    d5_d = p4_q[47:35];
    t5_d = 24'(d5_d) * 24'(JulCycle);
  end

  always_comb begin
    e6_d = 9'(c5_q - 22'(t5_q[23:2]));
  end

  jdcd_month_split u_month_split (
    .day_offset_i (e6_q),
    .split_o      (split)
  );

  always_comb begin
    ysum = 26'(yb6_q) + 26'(d6_q) + 26'(split.wrap);
    bc_d = ysum <= EpochYear;
    if (bc_d) begin
      year_d = 24'(EpochYear + 26'd1 - ysum);
    end else begin
      year_d = 24'(ysum - EpochYear);
    end
  end

  always_ff @(posedge clk_i) begin
    jd_q    <= julian_day_i;
    n1_q    <= n1_d;
    p1_q    <= p1_d;
    greg1_q <= greg1_d;
    cjul1_q <= cjul1_d;
    n2_q    <= n1_q;
    q0_q    <= q0_d;
    t_q     <= t_d;
    greg2_q <= greg1_q;
    cjul2_q <= cjul1_q;
    c3_q    <= c3_d;
    b3_q    <= b_d;
    greg3_q <= greg2_q;
    c4_q    <= c3_q;
    p4_q    <= p4_d;
    yb4_q   <= yb4_d;
    c5_q    <= c4_q;
    d5_q    <= d5_d;
    t5_q    <= t5_d;
    yb5_q   <= yb4_q;
    e6_q    <= e6_d;
    d6_q    <= d5_q;
    yb6_q   <= yb5_q;
    day_q   <= split.day;
    month_q <= split.month;
    year_q  <= year_d;
    bc_q    <= bc_d;
  end

  assign result_valid_o  = valid_q[7];
  assign day_of_month_o  = day_q;
  assign month_o         = month_q;
  assign year_o          = year_q;
  assign before_christ_o = bc_q;

  `JDCD_ASSERT_IMPL(a_strobe_follows_start, clk_i, rst_ni, result_valid_o, $past(start, ResultLatency), "result strobe without an accepted word")
  `JDCD_ASSERT_IMPL(a_date_range, clk_i, rst_ni, result_valid_o, month_o >= 4'd1 && month_o <= 4'd12 && day_of_month_o != 5'd0, "month or day out of range")
  `JDCD_ASSERT_IMPL(a_bc_year_range, clk_i, rst_ni, result_valid_o && before_christ_o, year_o <= MaxBcYear && year_o != 24'd0, "BC year out of range")
  `JDCD_ASSERT_IMPL(a_cycle_remainder, clk_i, rst_ni, valid_q[3] && greg3_q, c3_q <= 22'(GregCycle >> 2), "400-year remainder not corrected")
  `JDCD_ASSERT_IMPL(a_day_offset, clk_i, rst_ni, valid_q[6], e6_q <= MaxDayOffset, "day offset within year too large")

endmodule

// ===== tb/sv/jdcd_checker.sv =====
`timescale 1ns / 1ps
module jdcd_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] julian_day_i,
  input  logic        result_valid_o,
  input  logic [4:0]  day_of_month_o,
  input  logic [3:0]  month_o,
  input  logic [23:0] year_o,
  input  logic        before_christ_o,
  output int unsigned mismatch_count_o,
  output int unsigned dates_pending_o
);

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [23:0] year;
    logic        bc;
  } cal_date_t;

  cal_date_t expected_dates[$];

  // Day numbers up to the reform use the Julian calendar, later ones the Gregorian.
  function automatic cal_date_t predict_date(input logic [31:0] jd);
    longint shifted;
    longint cycle400;
    longint rem400;
    longint cycle4;
    longint offset;
    longint mo;
    longint yr;
    cal_date_t r;
    if (jd <= jdcd_pkg::LastJulianDay) begin
      shifted = longint'({32'd0, jd}) + 32082;
      cycle4  = (4 * shifted + 3) / 1461;
      offset  = shifted - (1461 * cycle4) / 4;
      yr      = cycle4 - 4800;
    end else begin
      shifted  = longint'({32'd0, jd}) + 32044;
      cycle400 = (4 * shifted + 3) / 146097;
      rem400   = shifted - (146097 * cycle400) / 4;
      cycle4   = (4 * rem400 + 3) / 1461;
      offset   = rem400 - (1461 * cycle4) / 4;
      yr       = 100 * cycle400 + cycle4 - 4800;
    end
    mo      = (5 * offset + 2) / 153;
    r.day   = 5'(offset - (153 * mo + 2) / 5 + 1);
    r.month = 4'(mo + 3 - 12 * (mo / 10));
    yr      = yr + mo / 10;
    if (yr <= 0) begin
      r.year = 24'(1 - yr);
      r.bc   = 1'b1;
    end else begin
      r.year = 24'(yr);
      r.bc   = 1'b0;
    end
    return r;
  endfunction

  task automatic note_mismatch(input string what, input cal_date_t want, input cal_date_t got);
    mismatch_count_o = mismatch_count_o + 1;
    if (mismatch_count_o <= 10) begin
      $display("%0t: %s: expected %0d-%0d-%0d bc %0d, got %0d-%0d-%0d bc %0d",
               $realtime, what, want.day, want.month, want.year, want.bc,
               got.day, got.month, got.year, got.bc);
    end
  endtask

  always @(posedge clk_i) begin
    cal_date_t got;
    cal_date_t want;
    if (rst_ni) begin
      if (result_valid_o) begin
        got = '{day: day_of_month_o, month: month_o, year: year_o, bc: before_christ_o};
        if (expected_dates.size() == 0) begin
          note_mismatch("unexpected word", '0, got);
        end else begin
          want = expected_dates.pop_front();
          if (got !== want) begin
            note_mismatch("date mismatch", want, got);
          end
        end
      end
      if (start && !busy) begin
        expected_dates.push_back(predict_date(julian_day_i));
      end
    end
    dates_pending_o <= expected_dates.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned RandomWords = 900;
  localparam int unsigned CycleLimit  = 50000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic [31:0] julian_day_i = '0;
  logic        busy;
  logic        result_valid_o;
  logic [4:0]  day_of_month_o;
  logic [3:0]  month_o;
  logic [23:0] year_o;
  logic        before_christ_o;
  int unsigned mismatch_count;
  int unsigned dates_pending;
  int unsigned cycle_count = 0;

  julian_day_to_calendar_date DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .julian_day_i   (julian_day_i),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .day_of_month_o (day_of_month_o),
    .month_o        (month_o),
    .year_o         (year_o),
    .before_christ_o(before_christ_o)
  );

  jdcd_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .julian_day_i    (julian_day_i),
    .result_valid_o  (result_valid_o),
    .day_of_month_o  (day_of_month_o),
    .month_o         (month_o),
    .year_o          (year_o),
    .before_christ_o (before_christ_o),
    .mismatch_count_o(mismatch_count),
    .dates_pending_o (dates_pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_word(input logic [31:0] jd, input bit may_idle);
    if (may_idle && $urandom_range(99) < 36) begin
      start <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < 36) @(posedge clk_i);
    end
    start        <= 1'b1;
    julian_day_i <= jd;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (dates_pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_day();
    case ($urandom_range(4))
      0:       return $urandom;
      1:       return $urandom_range(2500000);
      2:       return 32'd2299160 - 32'd400 + $urandom_range(800);
      3:       return $urandom_range(3000);
      default: return 32'hFFFF_FFFF - $urandom_range(200000);
    endcase
  endfunction

  initial begin
    logic [31:0] directed_days[$];
    directed_days = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd365, 32'd1721423, 32'd1721424,
                      32'd2299159, 32'd2299160, 32'd2299161, 32'd2299162, 32'd2415079,
                      32'd2415080, 32'd2451604, 32'd2451605, 32'h5555_5555,
                      32'hAAAA_AAAA, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFE,
                      32'hFFFF_FFFF};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_days[i]) send_word(directed_days[i], 1'b1);
    drain_results();
    for (int unsigned n = 0; n < RandomWords; n++) begin
      // A run of back-to-back words keeps the pipeline full.
      send_word(pick_day(), !(n >= 200 && n < 400));
      if (n == 450) drain_results();
    end
    drain_results();
    repeat (jdcd_pkg::ResultLatency + 8) @(posedge clk_i);
    if (mismatch_count == 0 && dates_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
